### sv/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg: shared types and constants for the segment intersection pipeline
// Widths of every intermediate result follow from the coordinate width.
// ----------------------------------------------------------------------------
package sip_pkg;

   localparam int COORD_BITS = 13;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int SIDE_BITS  = PROD_BITS + 2;
   localparam int DEN_BITS   = PROD_BITS + 1;
   localparam int TRI_BITS   = 3 * DIFF_BITS;
   localparam int NUM_BITS   = TRI_BITS + 2;
   localparam int QUO_BITS   = COORD_BITS + 1;
   localparam int DIV_STEPS  = QUO_BITS;
   // Four front stages, one magnitude stage, the divider and the output register.
   localparam int LATENCY    = 6 + DIV_STEPS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [SIDE_BITS-1:0]  side_type;
   typedef logic signed [DEN_BITS-1:0]   den_type;
   typedef logic signed [TRI_BITS-1:0]   tri_type;
   typedef logic signed [NUM_BITS-1:0]   num_type;
   typedef logic        [NUM_BITS-1:0]   mag_type;
   typedef logic        [QUO_BITS-1:0]   quo_type;

   localparam quo_type   QUO_POS_MAX = quo_type'((2 ** (COORD_BITS - 1)) - 1);
   localparam quo_type   QUO_NEG_MAX = quo_type'(2 ** (COORD_BITS - 1));
   localparam coord_type COORD_MAX   = coord_type'((2 ** (COORD_BITS - 1)) - 1);
   localparam coord_type COORD_MIN   = coord_type'(-(2 ** (COORD_BITS - 1)));

   typedef struct packed {
      logic    valid;
      logic    crosses;
      logic    degen;
      num_type num_x;
      num_type num_y;
      den_type den;
   } front_type;

   typedef struct packed {
      logic    valid;
      logic    crosses;
      logic    degen;
      logic    neg_x;
      logic    neg_y;
      mag_type rem_x;
      mag_type rem_y;
      mag_type dsh;
      quo_type q_x;
      quo_type q_y;
   } div_type;

endpackage

### sv/sip_front.sv
// ----------------------------------------------------------------------------
// sip_front: crossing test, denominator and numerators
// Four register stages: differences, products, sums and triple products,
// final numerator sums.
// ----------------------------------------------------------------------------
module sip_front import sip_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  coord_type a_x,
   input  coord_type a_y,
   input  coord_type b_x,
   input  coord_type b_y,
   input  coord_type c_x,
   input  coord_type c_y,
   input  coord_type d_x,
   input  coord_type d_y,
   output front_type front
);

   function automatic logic rejects(side_type s1, side_type s2);
      logic same;
      same = (s1[SIDE_BITS-1] == s2[SIDE_BITS-1]);
      return same && !((s1 == '0) && (s2 == '0));
   endfunction

   function automatic prod_type mul(diff_type x, diff_type y);
      return prod_type'(x) * prod_type'(y);
   endfunction

   function automatic tri_type mul3(prod_type x, diff_type y);
      return tri_type'(x) * tri_type'(y);
   endfunction

   // Stage 1: extended coordinates and differences.
   logic     v1_ff;
   diff_type ax_ff, bx_ff, by_ff, cx_ff, dx_ff, dy_ff;
   diff_type cy_by_ff, ay_cy_ff, by_ay_ff, dy_by_ff, ay_dy_ff, cy_ay_ff;
   diff_type dy_cy_ff, by_dy_ff, dx_cx_ff, ay_by_ff, bx_ax_ff, cy_dy_ff, dx_bx_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= in_valid;
      ax_ff    <= diff_type'(a_x);
      bx_ff    <= diff_type'(b_x);
      by_ff    <= diff_type'(b_y);
      cx_ff    <= diff_type'(c_x);
      dx_ff    <= diff_type'(d_x);
      dy_ff    <= diff_type'(d_y);
      cy_by_ff <= diff_type'(c_y) - diff_type'(b_y);
      ay_cy_ff <= diff_type'(a_y) - diff_type'(c_y);
      by_ay_ff <= diff_type'(b_y) - diff_type'(a_y);
      dy_by_ff <= diff_type'(d_y) - diff_type'(b_y);
      ay_dy_ff <= diff_type'(a_y) - diff_type'(d_y);
      cy_ay_ff <= diff_type'(c_y) - diff_type'(a_y);
      dy_cy_ff <= diff_type'(d_y) - diff_type'(c_y);
      by_dy_ff <= diff_type'(b_y) - diff_type'(d_y);
      dx_cx_ff <= diff_type'(d_x) - diff_type'(c_x);
      ay_by_ff <= diff_type'(a_y) - diff_type'(b_y);
      bx_ax_ff <= diff_type'(b_x) - diff_type'(a_x);
      cy_dy_ff <= diff_type'(c_y) - diff_type'(d_y);
      dx_bx_ff <= diff_type'(d_x) - diff_type'(b_x);
   end

   // Stage 2: all two-factor products.
   logic     v2_ff;
   prod_type t11_ff, t12_ff, t13_ff, t21_ff, t22_ff, t23_ff;
   prod_type t31_ff, t32_ff, t33_ff, t41_ff, t42_ff, t43_ff;
   prod_type k1_ff, k2_ff, p1_ff, p2_ff, p3_ff, r1_ff, r2_ff, r3_ff;
   diff_type e_ff, f_ff, g_ff, h_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      t11_ff <= mul(ax_ff, cy_by_ff);
      t12_ff <= mul(bx_ff, ay_cy_ff);
      t13_ff <= mul(cx_ff, by_ay_ff);
      t21_ff <= mul(ax_ff, dy_by_ff);
      t22_ff <= mul(bx_ff, ay_dy_ff);
      t23_ff <= mul(dx_ff, by_ay_ff);
      t31_ff <= mul(cx_ff, ay_dy_ff);
      t32_ff <= mul(dx_ff, cy_ay_ff);
      t33_ff <= mul(ax_ff, dy_cy_ff);
      t41_ff <= mul(cx_ff, by_dy_ff);
      t42_ff <= mul(dx_ff, cy_by_ff);
      t43_ff <= mul(bx_ff, dy_cy_ff);
      k1_ff  <= mul(dx_cx_ff, ay_by_ff);
      k2_ff  <= mul(bx_ax_ff, cy_dy_ff);
      p1_ff  <= mul(ay_cy_ff, bx_ax_ff);
      p2_ff  <= mul(cx_ff, dy_cy_ff);
      p3_ff  <= mul(ax_ff, by_ay_ff);
      r1_ff  <= mul(by_ff, bx_ax_ff);
      r2_ff  <= mul(dx_bx_ff, dy_cy_ff);
      r3_ff  <= mul(dy_ff, dx_cx_ff);
      e_ff   <= bx_ax_ff;
      f_ff   <= dx_cx_ff;
      g_ff   <= dy_cy_ff;
      h_ff   <= by_ay_ff;
   end

   // Stage 3: side tests, denominator and the third factor of each term.
   side_type s1, s2, s3, s4;
   logic     crosses_in;

   always_comb begin
      s1 = side_type'(t11_ff) + side_type'(t12_ff) + side_type'(t13_ff);
      s2 = side_type'(t21_ff) + side_type'(t22_ff) + side_type'(t23_ff);
      s3 = side_type'(t31_ff) + side_type'(t32_ff) + side_type'(t33_ff);
      s4 = side_type'(t41_ff) + side_type'(t42_ff) + side_type'(t43_ff);
      crosses_in = !rejects(s1, s2) && !rejects(s3, s4);
   end

   logic    v3_ff, crosses3_ff;
   den_type den3_ff;
   tri_type u1_ff, u2_ff, u3_ff, w1_ff, w2_ff, w3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      crosses3_ff <= crosses_in;
      den3_ff     <= den_type'(k1_ff) - den_type'(k2_ff);
      u1_ff       <= mul3(p1_ff, f_ff);
      u2_ff       <= mul3(p2_ff, e_ff);
      u3_ff       <= mul3(p3_ff, f_ff);
      w1_ff       <= mul3(r1_ff, g_ff);
      w2_ff       <= mul3(r2_ff, h_ff);
      w3_ff       <= mul3(r3_ff, h_ff);
   end

   // Stage 4: numerators. The y denominator is the negated x denominator.
   front_type front_ff;

   always_ff @(posedge clock) begin
      if (reset) front_ff.valid <= 1'b0;
      else       front_ff.valid <= v3_ff;
      front_ff.crosses <= crosses3_ff;
      front_ff.degen   <= crosses3_ff && (den3_ff == '0);
      front_ff.den     <= den3_ff;
      front_ff.num_x   <= num_type'(u1_ff) + num_type'(u2_ff) - num_type'(u3_ff);
      front_ff.num_y   <= num_type'(w3_ff) - num_type'(w1_ff) - num_type'(w2_ff);
   end

   assign front = front_ff;

endmodule

### sv/sip_div_step.sv
// ----------------------------------------------------------------------------
// sip_div_step: one restoring division step for both coordinates
// The shared divisor is shifted right by one on the way to the next step.
// ----------------------------------------------------------------------------
module sip_div_step import sip_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  div_type stage_in,
   output div_type stage_out
);

   logic    ge_x, ge_y;
   div_type stage_in_c;

   always_comb begin
      ge_x = (stage_in.rem_x >= stage_in.dsh);
      ge_y = (stage_in.rem_y >= stage_in.dsh);
      stage_in_c       = stage_in;
      stage_in_c.rem_x = ge_x ? (stage_in.rem_x - stage_in.dsh) : stage_in.rem_x;
      stage_in_c.rem_y = ge_y ? (stage_in.rem_y - stage_in.dsh) : stage_in.rem_y;
      stage_in_c.dsh   = stage_in.dsh >> 1;
      stage_in_c.q_x   = {stage_in.q_x[QUO_BITS-2:0], ge_x};
      stage_in_c.q_y   = {stage_in.q_y[QUO_BITS-2:0], ge_y};
   end

   div_type stage_ff;

   always_ff @(posedge clock) begin
      if (reset) stage_ff <= '0;
      else       stage_ff <= stage_in_c;
   end

   assign stage_out = stage_ff;

endmodule

### sv/segment_intersection_point.sv
// ----------------------------------------------------------------------------
// segment_intersection_point: crossing test and crossing point of two segments
// Pipelined side tests, numerators and a restoring divider, one pair a cycle.
// ----------------------------------------------------------------------------
//  Channel   Ports                      Transfer
//  request   start, busy, req_*         start high while busy low
//  response  rsp_valid, rsp_*           one cycle with rsp_valid high
//
//  A pair is taken every cycle; busy stays low.
//  The response passes through four front stages, one magnitude stage,
//  fourteen divider steps and the output register after the transfer.
//  Synchronous reset clears all valid bits; items in flight are dropped.
//  The receiver cannot stall, so nothing in the pipeline ever waits.
module segment_intersection_point import sip_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  coord_type req_a_x,
   input  coord_type req_a_y,
   input  coord_type req_b_x,
   input  coord_type req_b_y,
   input  coord_type req_c_x,
   input  coord_type req_c_y,
   input  coord_type req_d_x,
   input  coord_type req_d_y,
   output logic      rsp_valid,
   output logic      rsp_crosses,
   output coord_type rsp_cross_x,
   output coord_type rsp_cross_y,
   output logic      rsp_degenerate
);

   function automatic coord_type clamp(logic neg, quo_type q);
      quo_type nq;
      nq = quo_type'(0) - q;
      if (neg) return (q > QUO_NEG_MAX) ? COORD_MIN : coord_type'(nq);
      return (q > QUO_POS_MAX) ? COORD_MAX : coord_type'(q);
   endfunction

   assign busy = 1'b0;

   front_type front;

   sip_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .a_x      (req_a_x),
      .a_y      (req_a_y),
      .b_x      (req_b_x),
      .b_y      (req_b_y),
      .c_x      (req_c_x),
      .c_y      (req_c_y),
      .d_x      (req_d_x),
      .d_y      (req_d_y),
      .front    (front)
   );

   // Magnitudes and quotient signs. The divisor starts at its top step.
   den_type den_mag;
   div_type mag_in;

   always_comb begin
      den_mag = front.den[DEN_BITS-1] ? -front.den : front.den;
      mag_in.valid   = front.valid;
      mag_in.crosses = front.crosses;
      mag_in.degen   = front.degen;
      mag_in.neg_x   = front.num_x[NUM_BITS-1] ^ front.den[DEN_BITS-1];
      mag_in.neg_y   = front.num_y[NUM_BITS-1] ^ ~front.den[DEN_BITS-1];
      mag_in.rem_x   = mag_type'(front.num_x[NUM_BITS-1] ? -front.num_x : front.num_x);
      mag_in.rem_y   = mag_type'(front.num_y[NUM_BITS-1] ? -front.num_y : front.num_y);
      mag_in.dsh     = mag_type'(den_mag) << (QUO_BITS - 1);
      mag_in.q_x     = '0;
      mag_in.q_y     = '0;
   end

   div_type chain [DIV_STEPS+1];
   div_type mag_ff;

   always_ff @(posedge clock) begin
      if (reset) mag_ff <= '0;
      else       mag_ff <= mag_in;
   end

   assign chain[0] = mag_ff;

   // A quotient above QUO_POS_MAX, or above QUO_NEG_MAX when negative, is out of range; clamp saturates it.
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      sip_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   div_type   last;
   logic      rsp_valid_ff, crosses_ff, degen_ff;
   coord_type cross_x_ff, cross_y_ff;
   logic      point_ok;

   assign last     = chain[DIV_STEPS];
   assign point_ok = last.crosses && !last.degen;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= last.valid;
      crosses_ff <= last.crosses;
      degen_ff   <= last.degen;
      cross_x_ff <= point_ok ? clamp(last.neg_x, last.q_x) : '0;
      cross_y_ff <= point_ok ? clamp(last.neg_y, last.q_y) : '0;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_crosses    = crosses_ff;
   assign rsp_degenerate = degen_ff;
   assign rsp_cross_x    = cross_x_ff;
   assign rsp_cross_y    = cross_y_ff;

endmodule

### sv/sip_checker.sv
// ----------------------------------------------------------------------------
// sip_checker: port-level checks for segment_intersection_point
// Busy low, latency, flag consistency and the zeroed point fields.
// ----------------------------------------------------------------------------
module sip_checker import sip_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      start,
   input logic      busy,
   input logic      rsp_valid,
   input logic      rsp_crosses,
   input coord_type rsp_cross_x,
   input coord_type rsp_cross_y,
   input logic      rsp_degenerate
);

   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("response missing after transfer");

   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("response without matching transfer");

   a_no_cross: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_crosses) |->
         (rsp_cross_x == '0 && rsp_cross_y == '0 && !rsp_degenerate))
      else $error("fields set without crossing");

   a_degen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_crosses && rsp_cross_x == '0 && rsp_cross_y == '0))
      else $error("degenerate response with point");

endmodule

bind segment_intersection_point sip_checker u_sip_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_crosses    (rsp_crosses),
   .rsp_cross_x    (rsp_cross_x),
   .rsp_cross_y    (rsp_cross_y),
   .rsp_degenerate (rsp_degenerate)
);
